FILE: hw/rtl/ard_pkg.sv
// ----------------------------------------------------------------------------
// ard_pkg: shared types and constants of the adaptive range decoder
// Symbol count, table depths, item kinds, result codes and the phase rule.
// ----------------------------------------------------------------------------
package ard_pkg;

   // Model geometry.
   localparam int SYM_NUM   = 257;
   localparam int CUM_DEPTH = 258;
   localparam int ADDR_W    = 9;
   localparam int FREQ_W    = 16;
   localparam int CUM_W     = 17;

   // Table addresses used by the sequencer.
   localparam logic [ADDR_W-1:0] TOTAL_ADDR = 9'd257;
   localparam logic [ADDR_W-1:0] LAST_SYM   = 9'd256;

   // Arithmetic constants.
   localparam logic [31:0] RANGE_INIT  = 32'hFFFF_FFFF;
   localparam logic [31:0] TOTAL_LIMIT = 32'h0001_0000;
   localparam logic [31:0] TOP_MASK    = 32'hFF00_0000;

   // Item kinds carried on the request tuser.
   localparam logic [1:0] FUNC_START  = 2'd0;
   localparam logic [1:0] FUNC_SUPPLY = 2'd1;

   // Result status codes.
   localparam logic [2:0] ST_SYMBOL    = 3'd0;
   localparam logic [2:0] ST_STARTED   = 3'd1;
   localparam logic [2:0] ST_TAKEN     = 3'd2;
   localparam logic [2:0] ST_NEEDS     = 3'd3;
   localparam logic [2:0] ST_UNWANTED  = 3'd4;
   localparam logic [2:0] ST_NOT_START = 3'd5;

   // Renormalization phases.
   localparam logic [1:0] PH_READY  = 2'd0;
   localparam logic [1:0] PH_FIRST  = 2'd1;
   localparam logic [1:0] PH_SECOND = 2'd2;
   localparam logic [1:0] PH_IDLE   = 2'd3;

   // Phase that follows a first-phase step or a decode.
   function automatic logic [1:0] phase_after(input logic [31:0] low,
                                              input logic [31:0] range);
      logic [31:0] top;
      top = ((low + range) ^ low) & TOP_MASK;
      if (top == 32'd0) begin
         return PH_FIRST;
      end else if (range < TOTAL_LIMIT) begin
         return PH_SECOND;
      end else begin
         return PH_READY;
      end
   endfunction

endpackage

FILE: hw/rtl/ard_ram.sv
// ----------------------------------------------------------------------------
// ard_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ard_ram #(
   parameter int WIDTH  = 16,
   parameter int DEPTH  = 257,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/ard_div.sv
// ----------------------------------------------------------------------------
// ard_div: 32-bit restoring divider
// Produces one quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module ard_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [32:0] trial;

   // One shift-subtract step per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         rem_in  = 32'd0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         if (trial[32]) begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/adaptive_range_decoder_core.sv
// Start runs the table rebuild sweep; byte and status items go straight to the result.
// Decode runs two divisions, a binary search, a walk over the cumulative entries above symbol s,
// and, when counts are halved, a pass that rebuilds both tables.
// Throughput: one item at a time; the next item is taken once the result is registered.
// Reset: synchronous; a pass rebuilds both tables while req_tready stays low.
// ----------------------------------------------------------------------------
// adaptive_range_decoder_core: range decoder with adaptive order-0 model
// Sequencer around the frequency and cumulative tables and a serial divider.
// ----------------------------------------------------------------------------
module adaptive_range_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // code_word[31:0], data_byte[39:32]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // symbol[8:0], zero pad[15:9]
   output logic [3:0]  rsp_tuser    // status[2:0], wants_byte[3]
);

   localparam int AW = ard_pkg::ADDR_W;
   localparam int CW = ard_pkg::CUM_W;
   localparam int FW = ard_pkg::FREQ_W;

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_CLR  = 5'd1;
   localparam logic [4:0] S_TOT  = 5'd2;
   localparam logic [4:0] S_DQG  = 5'd3;
   localparam logic [4:0] S_DQ   = 5'd4;
   localparam logic [4:0] S_DV   = 5'd5;
   localparam logic [4:0] S_SRD  = 5'd6;
   localparam logic [4:0] S_SCMP = 5'd7;
   localparam logic [4:0] S_FRD  = 5'd8;
   localparam logic [4:0] S_MUL  = 5'd9;
   localparam logic [4:0] S_ADD  = 5'd10;
   localparam logic [4:0] S_IRD  = 5'd11;
   localparam logic [4:0] S_IWR  = 5'd12;
   localparam logic [4:0] S_RRD  = 5'd13;
   localparam logic [4:0] S_RWR  = 5'd14;
   localparam logic [4:0] S_PH   = 5'd15;
   localparam logic [4:0] S_FIN  = 5'd16;

   logic [4:0]    state_ff, state_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] lo_ff, lo_in;
   logic [AW-1:0] hi_ff, hi_in;
   logic [AW-1:0] mid_ff, mid_in;
   logic [AW-1:0] sym_ff, sym_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] csum_ff, csum_in;
   logic [31:0]   q_ff, q_in;
   logic [31:0]   v_ff, v_in;
   logic [31:0]   rprod_ff, rprod_in;
   logic [31:0]   cprod_ff, cprod_in;
   logic [31:0]   low_ff, low_in;
   logic [31:0]   range_ff, range_in;
   logic [31:0]   code_ff, code_in;
   logic [1:0]    phase_ff, phase_in;
   logic          clr_rsp_ff, clr_rsp_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic [AW-1:0] res_sym_ff, res_sym_in;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [3:0]    rsp_tuser_ff, rsp_tuser_in;

   // Table ports.
   logic          freq_we, cum_we;
   logic [AW-1:0] freq_waddr, freq_raddr, cum_waddr, cum_raddr;
   logic [FW-1:0] freq_wdata, freq_rdata;
   logic [CW-1:0] cum_wdata, cum_rdata;

   // Divider port.
   logic        div_start, div_done;
   logic [31:0] div_dividend, div_divisor, div_quot;

   // Scratch values.
   logic          accept;
   logic [31:0]   sh_low, sh_range, sh_code, r0;
   logic [AW:0]   mid_sum;
   logic [CW-1:0] cum_inc, tot_m1;
   logic [FW-1:0] half_f;
   logic [47:0]   fprod;
   logic [48:0]   cprod_w;

   ard_ram #(.WIDTH(FW), .DEPTH(ard_pkg::SYM_NUM), .ADDR_W(AW)) u_freq (
      .clock   (clock),
      .wr_en   (freq_we),
      .wr_addr (freq_waddr),
      .wr_data (freq_wdata),
      .rd_addr (freq_raddr),
      .rd_data (freq_rdata)
   );

   ard_ram #(.WIDTH(CW), .DEPTH(ard_pkg::CUM_DEPTH), .ADDR_W(AW)) u_cum (
      .clock   (clock),
      .wr_en   (cum_we),
      .wr_addr (cum_waddr),
      .wr_data (cum_wdata),
      .rd_addr (cum_raddr),
      .rd_data (cum_rdata)
   );

   ard_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   // Sequencer: next state, table accesses and datapath.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      sym_in        = sym_ff;
      total_in      = total_ff;
      csum_in       = csum_ff;
      q_in          = q_ff;
      v_in          = v_ff;
      rprod_in      = rprod_ff;
      cprod_in      = cprod_ff;
      low_in        = low_ff;
      range_in      = range_ff;
      code_in       = code_ff;
      phase_in      = phase_ff;
      clr_rsp_in    = clr_rsp_ff;
      res_status_in = res_status_ff;
      res_sym_in    = res_sym_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      freq_we    = 1'b0;
      freq_waddr = idx_ff;
      freq_wdata = '0;
      freq_raddr = idx_ff;
      cum_we     = 1'b0;
      cum_waddr  = idx_ff;
      cum_wdata  = '0;
      cum_raddr  = idx_ff;

      div_start    = 1'b0;
      div_dividend = range_ff;
      div_divisor  = q_ff;

      sh_low   = low_ff << 8;
      sh_range = range_ff << 8;
      sh_code  = {code_ff[23:0], req_tdata[39:32]};
      r0       = ard_pkg::TOTAL_LIMIT - {16'd0, low_ff[15:0]};
      mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} + {{AW{1'b0}}, 1'b1};
      cum_inc  = cum_rdata + {{(CW-1){1'b0}}, 1'b1};
      tot_m1   = total_ff - {{(CW-1){1'b0}}, 1'b1};
      half_f   = (freq_rdata | {{(FW-2){1'b0}}, 2'b10}) >> 1;
      fprod    = freq_rdata * q_ff;
      cprod_w  = cum_rdata * q_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_sym_in = '0;
               state_in   = S_FIN;
               if (req_tuser == ard_pkg::FUNC_START) begin
                  code_in    = req_tdata[31:0];
                  idx_in     = '0;
                  clr_rsp_in = 1'b1;
                  state_in   = S_CLR;
               end else if (phase_ff == ard_pkg::PH_IDLE) begin
                  res_status_in = ard_pkg::ST_NOT_START;
               end else if (req_tuser == ard_pkg::FUNC_SUPPLY) begin
                  // Renormalization byte, first or second phase.
                  if (phase_ff == ard_pkg::PH_FIRST) begin
                     low_in        = sh_low;
                     range_in      = sh_range;
                     code_in       = sh_code;
                     phase_in      = ard_pkg::phase_after(sh_low, sh_range);
                     res_status_in = ard_pkg::ST_TAKEN;
                  end else if (phase_ff == ard_pkg::PH_SECOND) begin
                     low_in        = sh_low;
                     range_in      = r0 << 8;
                     code_in       = sh_code;
                     phase_in      = ((r0 << 8) < ard_pkg::TOTAL_LIMIT) ?
                                     ard_pkg::PH_SECOND : ard_pkg::PH_READY;
                     res_status_in = ard_pkg::ST_TAKEN;
                  end else begin
                     res_status_in = ard_pkg::ST_UNWANTED;
                  end
               end else if (phase_ff != ard_pkg::PH_READY) begin
                  res_status_in = ard_pkg::ST_NEEDS;
               end else begin
                  state_in = S_TOT;
               end
            end
         end
         S_CLR: begin
            // Rebuild sweep: freq[i] = 1, cum[i] = i.
            freq_we    = (idx_ff != ard_pkg::TOTAL_ADDR);
            freq_wdata = {{(FW-1){1'b0}}, 1'b1};
            cum_we     = 1'b1;
            cum_wdata  = {{(CW-AW){1'b0}}, idx_ff};
            idx_in     = idx_ff + {{(AW-1){1'b0}}, 1'b1};
            if (idx_ff == ard_pkg::TOTAL_ADDR) begin
               if (clr_rsp_ff) begin
                  low_in        = '0;
                  range_in      = ard_pkg::RANGE_INIT;
                  phase_in      = ard_pkg::PH_READY;
                  res_status_in = ard_pkg::ST_STARTED;
                  state_in      = S_FIN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_TOT: begin
            cum_raddr = ard_pkg::TOTAL_ADDR;
            state_in  = S_DQG;
         end
         S_DQG: begin
            // First division: range by the total.
            total_in     = (cum_rdata == '0) ? {{(CW-1){1'b0}}, 1'b1} : cum_rdata;
            div_start    = 1'b1;
            div_dividend = range_ff;
            div_divisor  = (cum_rdata == '0) ? 32'd1 : {{(32-CW){1'b0}}, cum_rdata};
            state_in     = S_DQ;
         end
         S_DQ: begin
            if (div_done) begin
               q_in         = (div_quot == 32'd0) ? 32'd1 : div_quot;
               div_start    = 1'b1;
               div_dividend = code_ff - low_ff;
               div_divisor  = (div_quot == 32'd0) ? 32'd1 : div_quot;
               state_in     = S_DV;
            end
         end
         S_DV: begin
            if (div_done) begin
               v_in     = (div_quot > {{(32-CW){1'b0}}, tot_m1}) ?
                          {{(32-CW){1'b0}}, tot_m1} : div_quot;
               lo_in    = '0;
               hi_in    = ard_pkg::LAST_SYM;
               state_in = S_SRD;
            end
         end
         S_SRD: begin
            // Binary search for the last entry not above v.
            if (lo_ff == hi_ff) begin
               sym_in   = lo_ff;
               state_in = S_FRD;
            end else begin
               mid_in    = mid_sum[AW:1];
               cum_raddr = mid_sum[AW:1];
               state_in  = S_SCMP;
            end
         end
         S_SCMP: begin
            if ({{(32-CW){1'b0}}, cum_rdata} <= v_ff) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff - {{(AW-1){1'b0}}, 1'b1};
            end
            state_in = S_SRD;
         end
         S_FRD: begin
            freq_raddr = sym_ff;
            cum_raddr  = sym_ff;
            state_in   = S_MUL;
         end
         S_MUL: begin
            rprod_in   = fprod[31:0];
            cprod_in   = cprod_w[31:0];
            freq_we    = 1'b1;
            freq_waddr = sym_ff;
            freq_wdata = freq_rdata + {{(FW-1){1'b0}}, 1'b1};
            idx_in     = sym_ff + {{(AW-1){1'b0}}, 1'b1};
            state_in   = S_ADD;
         end
         S_ADD: begin
            low_in   = low_ff + cprod_ff;
            range_in = rprod_ff;
            state_in = S_IRD;
         end
         S_IRD: begin
            state_in = S_IWR;
         end
         S_IWR: begin
            // Bump every cumulative entry above the symbol.
            cum_we    = 1'b1;
            cum_wdata = cum_inc;
            if (idx_ff == ard_pkg::TOTAL_ADDR) begin
               if ({{(32-CW){1'b0}}, cum_inc} >= ard_pkg::TOTAL_LIMIT) begin
                  idx_in   = '0;
                  csum_in  = '0;
                  state_in = S_RRD;
               end else begin
                  state_in = S_PH;
               end
            end else begin
               idx_in   = idx_ff + {{(AW-1){1'b0}}, 1'b1};
               state_in = S_IRD;
            end
         end
         S_RRD: begin
            state_in = S_RWR;
         end
         S_RWR: begin
            // Halve counts and rebuild the running sums.
            freq_we    = 1'b1;
            freq_wdata = half_f;
            cum_we     = 1'b1;
            cum_waddr  = idx_ff + {{(AW-1){1'b0}}, 1'b1};
            cum_wdata  = csum_ff + {1'b0, half_f};
            csum_in    = csum_ff + {1'b0, half_f};
            idx_in     = idx_ff + {{(AW-1){1'b0}}, 1'b1};
            state_in   = (idx_ff == ard_pkg::LAST_SYM) ? S_PH : S_RRD;
         end
         S_PH: begin
            phase_in      = ard_pkg::phase_after(low_ff, range_ff);
            res_sym_in    = sym_ff;
            res_status_in = ard_pkg::ST_SYMBOL;
            state_in      = S_FIN;
         end
         S_FIN: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {{(16-AW){1'b0}}, res_sym_ff};
               rsp_tuser_in  = {(phase_ff == ard_pkg::PH_FIRST) ||
                                (phase_ff == ard_pkg::PH_SECOND), res_status_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLR;
         idx_ff        <= '0;
         clr_rsp_ff    <= 1'b0;
         phase_ff      <= ard_pkg::PH_IDLE;
         low_ff        <= '0;
         range_ff      <= ard_pkg::RANGE_INIT;
         code_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         clr_rsp_ff    <= clr_rsp_in;
         phase_ff      <= phase_in;
         low_ff        <= low_in;
         range_ff      <= range_in;
         code_ff       <= code_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      sym_ff        <= sym_in;
      total_ff      <= total_in;
      csum_ff       <= csum_in;
      q_ff          <= q_in;
      v_ff          <= v_in;
      rprod_ff      <= rprod_in;
      cprod_ff      <= cprod_in;
      res_status_ff <= res_status_in;
      res_sym_ff    <= res_sym_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

FILE: hw/rtl/ard_checker.sv
// ----------------------------------------------------------------------------
// ard_checker: port-level checks of the range decoder
// Watches the result channel for codes that cannot go together.
// ----------------------------------------------------------------------------
module ard_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [3:0]  rsp_tuser
);

   // A stalled result beat holds its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   // Only a decoded symbol carries a nonzero symbol.
   a_sym: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] != ard_pkg::ST_SYMBOL) |-> rsp_tdata[8:0] == 9'd0)
      else $error("symbol present on a non-symbol result");

   // A decode refused for lack of bytes always reports the wait.
   a_needs: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[2:0] == ard_pkg::ST_NEEDS) |-> rsp_tuser[3])
      else $error("needs-byte result without wants_byte");

   // Unwanted bytes, starts and idle refusals never leave a byte pending.
   a_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ((rsp_tuser[2:0] == ard_pkg::ST_UNWANTED) ||
                     (rsp_tuser[2:0] == ard_pkg::ST_STARTED) ||
                     (rsp_tuser[2:0] == ard_pkg::ST_NOT_START)) |-> !rsp_tuser[3])
      else $error("wants_byte set on a result that cannot wait");

endmodule

bind adaptive_range_decoder_core ard_checker u_ard_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
